// ===== hdl/msgtd_pkg.sv =====
// Shared types and constants for the MessagePack token decoder.
`timescale 1ns / 1ps
`default_nettype none
package msgtd_pkg;

  localparam logic [2:0] KIND_UNSIGNED = 3'd0;
  localparam logic [2:0] KIND_SIGNED   = 3'd1;
  localparam logic [2:0] KIND_BOOL     = 3'd2;
  localparam logic [2:0] KIND_BLOCK    = 3'd3;
  localparam logic [2:0] KIND_BYTE     = 3'd4;
  localparam logic [2:0] KIND_ARRAY    = 3'd5;
  localparam logic [2:0] KIND_MAP      = 3'd6;
  localparam logic [2:0] KIND_ERROR    = 3'd7;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_LEAD  = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;
  localparam logic [1:0] ERR_LONG  = 2'd3;

  localparam logic [15:0] MAX_BLOCK_LENGTH_RESET = 16'hffff;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_FIRST   = 4'b0010,
    PH_NEXT    = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [63:0] value;
    logic [15:0] length;
    logic [7:0]  payload_byte;
    logic        last_of_block;
    logic [1:0]  error_code;
  } result_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  pending_kind;
    logic [15:0] bytes_remaining;
    logic [63:0] value_accumulator;
    logic        skip_payload;
  } dec_state_t;

  localparam dec_state_t DEC_STATE_IDLE = '{
    phase:             PH_IDLE,
    pending_kind:      KIND_UNSIGNED,
    bytes_remaining:   16'd0,
    value_accumulator: 64'd0,
    skip_payload:      1'b0
  };

endpackage
`default_nettype wire

// ===== hdl/msgtd_step.sv =====
// Per-byte decode logic: current state and input byte to next state and result.
`timescale 1ns / 1ps
`default_nettype none
module msgtd_step
  import msgtd_pkg::*;
(
  input  dec_state_t  state,
  input  item_t       item,
  input  logic [15:0] max_block_length,
  output dec_state_t  state_next,
  output logic        res_valid,
  output result_t     res
);

  function automatic result_t make_result(input logic [2:0] kind, input logic [63:0] val,
                                          input logic [15:0] len, input logic [7:0] pbyte,
                                          input logic last, input logic [1:0] err);
    result_t r;
    r.token_kind    = kind;
    r.value         = val;
    r.length        = len;
    r.payload_byte  = pbyte;
    r.last_of_block = last;
    r.error_code    = err;
    return r;
  endfunction

  logic [7:0]  b;
  logic        eob;
  logic [63:0] acc_new;
  logic [15:0] rem_dec;
  logic        do_hdr;
  logic [15:0] hdr_len;
  logic        too_long;
  logic        do_collect;
  logic [2:0]  col_kind;
  logic [15:0] col_bytes;

  assign b   = item.data_byte;
  assign eob = item.end_of_buffer;

  always_comb begin
    if ((state.phase == PH_FIRST) && (state.pending_kind == KIND_SIGNED) && b[7]) begin
      acc_new = {56'hff_ffff_ffff_ffff, b};
    end else begin
      acc_new = {state.value_accumulator[55:0], b};
    end
  end

  assign rem_dec = state.bytes_remaining - 16'd1;

  always_comb begin
    state_next = DEC_STATE_IDLE;
    res_valid  = 1'b0;
    res        = make_result(KIND_UNSIGNED, 64'd0, 16'd0, 8'd0, 1'b0, ERR_NONE);
    do_hdr     = 1'b0;
    hdr_len    = 16'd0;
    do_collect = 1'b0;
    col_kind   = KIND_UNSIGNED;
    col_bytes  = 16'd0;
    too_long   = 1'b0;

    unique case (state.phase)
      PH_FIRST, PH_NEXT: begin
        if (rem_dec == 16'd0) begin
          case (state.pending_kind)
            KIND_BLOCK: begin
              do_hdr  = 1'b1;
              hdr_len = acc_new[15:0];
            end
            KIND_ARRAY, KIND_MAP: begin
              res_valid = 1'b1;
              res = make_result(state.pending_kind, 64'd0, acc_new[15:0], 8'd0, 1'b0,
                                ERR_NONE);
            end
            default: begin
              res_valid = 1'b1;
              res = make_result(state.pending_kind, acc_new, 16'd0, 8'd0, 1'b0, ERR_NONE);
            end
          endcase
        end else if (eob) begin
          res_valid = 1'b1;
          res = make_result(KIND_ERROR, 64'd0, 16'd0, 8'd0, 1'b0, ERR_TRUNC);
        end else begin
          state_next.phase             = PH_NEXT;
          state_next.pending_kind      = state.pending_kind;
          state_next.bytes_remaining   = rem_dec;
          state_next.value_accumulator = acc_new;
        end
      end
      PH_PAYLOAD: begin
        if (state.bytes_remaining <= 16'd1) begin
          res_valid = !state.skip_payload;
          res = make_result(KIND_BYTE, 64'd0, 16'd0, b, 1'b1, ERR_NONE);
        end else if (eob) begin
          res_valid = 1'b1;
          res = make_result(KIND_ERROR, 64'd0, 16'd0, 8'd0, 1'b0, ERR_TRUNC);
        end else begin
          state_next.phase           = PH_PAYLOAD;
          state_next.bytes_remaining = rem_dec;
          state_next.skip_payload    = state.skip_payload;
          res_valid = !state.skip_payload;
          res = make_result(KIND_BYTE, 64'd0, 16'd0, b, 1'b0, ERR_NONE);
        end
      end
      PH_IDLE: begin
        unique case (b) inside
          [8'h00:8'h7f]: begin
            res_valid = 1'b1;
            res = make_result(KIND_UNSIGNED, {56'd0, b}, 16'd0, 8'd0, 1'b0, ERR_NONE);
          end
          [8'he0:8'hff]: begin
            res_valid = 1'b1;
            res = make_result(KIND_SIGNED, {56'hff_ffff_ffff_ffff, b}, 16'd0, 8'd0, 1'b0,
                              ERR_NONE);
          end
          [8'ha0:8'hbf]: begin
            do_hdr  = 1'b1;
            hdr_len = {11'd0, b[4:0]};
          end
          [8'h90:8'h9f]: begin
            res_valid = 1'b1;
            res = make_result(KIND_ARRAY, 64'd0, {12'd0, b[3:0]}, 8'd0, 1'b0, ERR_NONE);
          end
          [8'h80:8'h8f]: begin
            res_valid = 1'b1;
            res = make_result(KIND_MAP, 64'd0, {12'd0, b[3:0]}, 8'd0, 1'b0, ERR_NONE);
          end
          8'hc2, 8'hc3: begin
            res_valid = 1'b1;
            res = make_result(KIND_BOOL, {63'd0, b[0]}, 16'd0, 8'd0, 1'b0, ERR_NONE);
          end
          8'hcc: begin do_collect = 1'b1; col_kind = KIND_UNSIGNED; col_bytes = 16'd1; end
          8'hcd: begin do_collect = 1'b1; col_kind = KIND_UNSIGNED; col_bytes = 16'd2; end
          8'hce: begin do_collect = 1'b1; col_kind = KIND_UNSIGNED; col_bytes = 16'd4; end
          8'hcf: begin do_collect = 1'b1; col_kind = KIND_UNSIGNED; col_bytes = 16'd8; end
          8'hd0: begin do_collect = 1'b1; col_kind = KIND_SIGNED; col_bytes = 16'd1; end
          8'hd1: begin do_collect = 1'b1; col_kind = KIND_SIGNED; col_bytes = 16'd2; end
          8'hd2: begin do_collect = 1'b1; col_kind = KIND_SIGNED; col_bytes = 16'd4; end
          8'hd3: begin do_collect = 1'b1; col_kind = KIND_SIGNED; col_bytes = 16'd8; end
          8'hd9, 8'hc4: begin do_collect = 1'b1; col_kind = KIND_BLOCK; col_bytes = 16'd1; end
          8'hda, 8'hc5: begin do_collect = 1'b1; col_kind = KIND_BLOCK; col_bytes = 16'd2; end
          8'hdc: begin do_collect = 1'b1; col_kind = KIND_ARRAY; col_bytes = 16'd2; end
          8'hde: begin do_collect = 1'b1; col_kind = KIND_MAP; col_bytes = 16'd2; end
          default: begin
            res_valid = 1'b1;
            res = make_result(KIND_ERROR, 64'd0, 16'd0, 8'd0, 1'b0, ERR_LEAD);
          end
        endcase
      end
      default: begin
        state_next = DEC_STATE_IDLE;
      end
    endcase

    if (do_collect) begin
      if (eob) begin
        res_valid = 1'b1;
        res = make_result(KIND_ERROR, 64'd0, 16'd0, 8'd0, 1'b0, ERR_TRUNC);
      end else begin
        state_next.phase           = PH_FIRST;
        state_next.pending_kind    = col_kind;
        state_next.bytes_remaining = col_bytes;
      end
    end

    if (do_hdr) begin
      too_long  = hdr_len > max_block_length;
      res_valid = 1'b1;
      if (too_long) begin
        res = make_result(KIND_ERROR, 64'd0, 16'd0, 8'd0, 1'b0, ERR_LONG);
      end else begin
        res = make_result(KIND_BLOCK, 64'd0, hdr_len, 8'd0, 1'b0, ERR_NONE);
      end
      if (hdr_len != 16'd0) begin
        if (eob) begin
          res = make_result(KIND_ERROR, 64'd0, 16'd0, 8'd0, 1'b0, ERR_TRUNC);
        end else begin
          state_next.phase           = PH_PAYLOAD;
          state_next.bytes_remaining = hdr_len;
          state_next.skip_payload    = too_long;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/msgtd_outbuf.sv =====
// Result register with a skid stage between decode logic and the output channel.
`timescale 1ns / 1ps
`default_nettype none
module msgtd_outbuf
  import msgtd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    push_ready,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic    main_valid;
  result_t main_data;
  logic    skid_valid;
  result_t skid_data;
  logic    main_free;

  assign push_ready   = !skid_valid;
  assign result_valid = main_valid;
  assign result       = main_data;
  assign main_free    = !main_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/msgtd_top_regs.sv =====
// Decoder state and block length limit registers.
`timescale 1ns / 1ps
`default_nettype none
module msgtd_top_regs
  import msgtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  dec_state_t  state_next,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output dec_state_t  state,
  output logic [15:0] max_block_length
);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= DEC_STATE_IDLE;
      max_block_length <= MAX_BLOCK_LENGTH_RESET;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (cfg_we) begin
        max_block_length <= cfg_wdata;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/msgpack_token_decoder.sv =====
// Top level of the MessagePack token decoder.
//
// Input channel item_valid/item_ready carries one buffer byte and an end of
// buffer flag per transfer. Output channel result_valid/result_ready carries
// one decoded token, one block payload byte, or an error per transfer; a
// byte that only advances a multi-byte token gives no result.
// The result of a completing byte is registered in the result register, or
// in the skid while the receiver stalls. One byte per cycle while the skid
// is empty, set by the single decode pass from state to result register.
// A two-entry output buffer (result register plus skid) keeps item_ready
// high while one result waits; item_ready drops only when both are full,
// so a stalled receiver holds the input after two pending results.
// cfg_we/cfg_wdata write the largest accepted block length; write it only
// while the block is idle.
// Reset (rst, synchronous) returns the decoder to await a lead byte, empties
// the output buffer and sets the block length limit to 65535.
`timescale 1ns / 1ps
`default_nettype none
module msgpack_token_decoder
  import msgtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  dec_state_t  state;
  dec_state_t  state_next;
  logic [15:0] max_block_length;
  logic        res_valid;
  result_t     res;
  logic        accept;

  assign accept = item_valid && item_ready;

  msgtd_top_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .advance          (accept),
    .state_next       (state_next),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .state            (state),
    .max_block_length (max_block_length)
  );

  msgtd_step u_step (
    .state            (state),
    .item             (item),
    .max_block_length (max_block_length),
    .state_next       (state_next),
    .res_valid        (res_valid),
    .res              (res)
  );

  msgtd_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .push         (accept && res_valid),
    .push_data    (res),
    .push_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
